[rtl/core/sorted_key_table_search_macros.svh]
// Assertion macros for the RTL that checks itself.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef SORTED_KEY_TABLE_SEARCH_MACROS_SVH
`define SORTED_KEY_TABLE_SEARCH_MACROS_SVH
`ifndef ASSERT_OFF
// Check a condition at every rising clock edge
`define SKTS_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Check a consequence in the cycle after its trigger
`define SKTS_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SKTS_ASSERT(name, prop, msg)
`define SKTS_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

[rtl/core/skts_pkg.sv]
`timescale 1ns / 1ps
package skts_pkg;

	// table geometry
	localparam int unsigned TABLE_DEPTH = 1024;
	localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

	// fixed field widths
	localparam int unsigned KEY_W = 32;
	localparam int unsigned OFS_W = 32;
	localparam int unsigned GEN_W = 32;
	localparam int unsigned IDX_W = 10;
	localparam int unsigned ENT_W = 11;
	localparam int unsigned ENTRY_W = KEY_W + OFS_W;

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_FIND   = 2'd1,
		OP_CLEAR  = 2'd2
	} op_e;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_MISSING = 2'd1,
		ST_FULL    = 2'd2,
		ST_ORDER   = 2'd3
	} status_e;

	typedef enum logic [1:0] {
		T_IDLE,
		T_EXEC,
		T_SEARCH,
		T_OUT
	} top_state_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PROBE,
		S_FIN
	} srch_state_t;

	// search request from control to the search engine
	typedef struct packed {
		logic             start;
		logic [KEY_W-1:0] key;
		logic [CNT_W-1:0] count;
	} srch_req_t;

	// search response back to control
	typedef struct packed {
		logic             done;
		logic             hit;
		logic [CNT_W-1:0] pos;
		logic [OFS_W-1:0] offset;
	} srch_rsp_t;

	// one result transaction
	typedef struct packed {
		status_e          status;
		logic [IDX_W-1:0] idx;
		logic [OFS_W-1:0] offset;
		logic [ENT_W-1:0] entries;
		logic [GEN_W-1:0] gen;
	} result_t;

endpackage

[rtl/core/sorted_key_table_search.sv]
`timescale 1ns / 1ps
`include "sorted_key_table_search_macros.svh"
// Sorted key table: up to TABLE_DEPTH entries of a 32-bit key and a 32-bit text offset, held
// in one synchronous RAM, appended in ascending key order and searched by lower-bound binary
// search. One item is processed at a time and every item yields one result transaction.
// Append, clear and the unused opcode pass from T_IDLE to T_EXEC, which registers the result
// in res_q, and then to T_OUT, which loads it into the output register. A find runs its P probes
// in T_SEARCH in place of T_EXEC, where P, the number of probes, is floor(log2(entries))
// or one more (11 at most for 1024 entries, 0 on an empty table); each probe is one read of
// the table RAM, whose registered read sets the pace. No clearing pass is needed after reset:
// only entries below the count ever affect a result. The input is taken again as soon as the
// result sits in the output register, even if it has not been taken yet; a result still
// waiting there holds the next one back until it is taken.
module sorted_key_table_search (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // key[31:0], entry_offset[63:32]
	input  logic [1:0]  s_tuser,   // op[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // found_index[9:0], found_offset[41:10], entries[52:42],
	                               // generation_now[84:53], zero[87:85]
	output logic [1:0]  m_tuser    // status[1:0]
);
	import skts_pkg::*;

	top_state_t         state_q, state_d;
	logic [1:0]         op_q;
	logic [KEY_W-1:0]   key_q, last_key_q;
	logic [OFS_W-1:0]   ofs_q;
	logic [CNT_W-1:0]   count_q;
	logic [GEN_W-1:0]   gen_q;
	result_t            res_q, out_q;
	logic               out_valid_q;

	srch_req_t          req;
	srch_rsp_t          rsp;
	logic [ADDR_W-1:0]  rd_addr;
	logic [ENTRY_W-1:0] rd_data;

	logic               accept, load_out, ram_we;
	logic               is_full, out_of_order;
	status_e            exec_status;

	// table storage: offset in the upper half, key in the lower half
	skts_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[ADDR_W-1:0]),
		.wdata({ofs_q, key_q}),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	skts_search u_search (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign accept   = s_tvalid && s_tready;
	assign load_out = (state_q == T_OUT) && (!out_valid_q || m_tready);

	// append checks
	assign is_full      = count_q >= CNT_W'(TABLE_DEPTH);
	assign out_of_order = (count_q != '0) && (key_q < last_key_q);

	always_comb begin
		exec_status = ST_OK;
		if (op_q == OP_APPEND) begin
			if (is_full) begin
				exec_status = ST_FULL;
			end else if (out_of_order) begin
				exec_status = ST_ORDER;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			T_IDLE: begin
				if (accept) begin
					state_d = (s_tuser == OP_FIND) ? T_SEARCH : T_EXEC;
				end
			end
			T_EXEC: state_d = T_OUT;
			T_SEARCH: begin
				if (rsp.done) begin
					state_d = T_OUT;
				end
			end
			T_OUT: begin
				if (load_out) begin
					state_d = T_IDLE;
				end
			end
			default: state_d = T_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		s_tready  = 1'b0;
		req.start = 1'b0;
		req.key   = s_tdata[KEY_W-1:0];
		req.count = count_q;
		ram_we    = 1'b0;
		case (state_q)
			T_IDLE: begin
				s_tready  = 1'b1;
				req.start = s_tvalid && (s_tuser == OP_FIND);
			end
			T_EXEC: begin
				ram_we = (op_q == OP_APPEND) && (exec_status == ST_OK);
			end
			default: ram_we = 1'b0;
		endcase
	end

	// hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			count_q     <= '0;
			gen_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == T_EXEC) begin
				if (op_q == OP_CLEAR) begin
					count_q <= '0;
					gen_q   <= gen_q + GEN_W'(1);
				end else if (ram_we) begin
					count_q <= count_q + CNT_W'(1);
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// capture the transaction, track the last key, build the result
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= s_tuser;
			key_q <= s_tdata[KEY_W-1:0];
			ofs_q <= s_tdata[63:KEY_W];
		end
		if (ram_we) begin
			last_key_q <= key_q;
		end
		if (state_q == T_EXEC) begin
			res_q.status <= exec_status;
			res_q.idx    <= '0;
			res_q.offset <= '0;
			res_q.gen    <= (op_q == OP_CLEAR) ? (gen_q + GEN_W'(1)) : gen_q;
			if (op_q == OP_CLEAR) begin
				res_q.entries <= '0;
			end else if (ram_we) begin
				res_q.entries <= ENT_W'(count_q + CNT_W'(1));
			end else begin
				res_q.entries <= ENT_W'(count_q);
			end
		end else if (state_q == T_SEARCH && rsp.done) begin
			res_q.status  <= rsp.hit ? ST_OK : ST_MISSING;
			res_q.idx     <= rsp.hit ? IDX_W'(rsp.pos) : '0;
			res_q.offset  <= rsp.hit ? rsp.offset : '0;
			res_q.entries <= ENT_W'(count_q);
			res_q.gen     <= gen_q;
		end
		if (load_out) begin
			out_q <= res_q;
		end
	end

	// output transaction
	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {3'b000, out_q.gen, out_q.entries, out_q.offset, out_q.idx};

	`SKTS_ASSERT(a_count_bound, count_q <= CNT_W'(TABLE_DEPTH), "entry count above depth")
	`SKTS_ASSERT_NEXT(a_one_item, accept, !s_tready, "second item taken while busy")
	`SKTS_ASSERT(a_done_in_search, !rsp.done || state_q == T_SEARCH, "stray search response")
	`SKTS_ASSERT_NEXT(a_clear_gen, state_q == T_EXEC && op_q == OP_CLEAR,
		gen_q == $past(gen_q) + GEN_W'(1) && count_q == '0, "clear did not advance")

endmodule

[rtl/core/skts_ram.sv]
`timescale 1ns / 1ps
module skts_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/skts_search.sv]
`timescale 1ns / 1ps
module skts_search (
	input  logic                        clk,
	input  logic                        arst_n,
	input  skts_pkg::srch_req_t         req,
	output skts_pkg::srch_rsp_t         rsp,
	output logic [skts_pkg::ADDR_W-1:0] rd_addr,
	input  logic [skts_pkg::ENTRY_W-1:0] rd_data
);
	import skts_pkg::*;

	srch_state_t      state_q, state_d;
	logic [CNT_W-1:0] lo_q, hi_q, mid_q, cnt_q;
	logic [KEY_W-1:0] probe_q;
	logic [CNT_W-1:0] nlo, nhi, nmid, start_mid;
	logic             below, more;
	logic [KEY_W-1:0] rd_key;
	logic [OFS_W-1:0] rd_ofs;

	assign rd_key    = rd_data[KEY_W-1:0];
	assign rd_ofs    = rd_data[ENTRY_W-1:KEY_W];
	assign start_mid = req.count >> 1;

	// narrow the window with the key read back for mid_q
	always_comb begin
		below = rd_key < probe_q;
		nlo   = below ? (mid_q + CNT_W'(1)) : lo_q;
		nhi   = below ? hi_q : mid_q;
		nmid  = nlo + ((nhi - nlo) >> 1);
		more  = nlo < nhi;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req.start) begin
					state_d = (req.count != '0) ? S_PROBE : S_FIN;
				end
			end
			S_PROBE: begin
				if (!more) begin
					state_d = S_FIN;
				end
			end
			S_FIN:   state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// read address and response
	always_comb begin
		rd_addr    = '0;
		rsp.done   = 1'b0;
		rsp.hit    = 1'b0;
		rsp.pos    = lo_q;
		rsp.offset = rd_ofs;
		case (state_q)
			S_IDLE: begin
				rd_addr = start_mid[ADDR_W-1:0];
			end
			S_PROBE: begin
				rd_addr = more ? nmid[ADDR_W-1:0] : nlo[ADDR_W-1:0];
			end
			S_FIN: begin
				rsp.done = 1'b1;
				rsp.hit  = (lo_q < cnt_q) && (rd_key == probe_q);
			end
			default: rd_addr = '0;
		endcase
	end

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// advance the search window
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.start) begin
			lo_q    <= '0;
			hi_q    <= req.count;
			mid_q   <= start_mid;
			cnt_q   <= req.count;
			probe_q <= req.key;
		end else if (state_q == S_PROBE) begin
			lo_q  <= nlo;
			hi_q  <= nhi;
			mid_q <= nmid;
		end
	end

endmodule
